[sv/merp_pkg.sv]
package merp_pkg;

  localparam int TABLE_DEPTH     = 4096;
  localparam int EVENTS_PER_TICK = 20;
  localparam int TIME_BITS       = 32;

  localparam int ADDR_BITS     = $clog2(TABLE_DEPTH);
  localparam int IDX_BITS      = ADDR_BITS + 1;
  localparam int CNT_BITS      = $clog2(EVENTS_PER_TICK + 1);
  localparam int LEAD_BITS     = 20;
  localparam int MASK_BITS     = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 20;

  localparam logic [MASK_BITS-1:0] MASK_RESET = 16'h00ff;
  localparam logic [LEAD_BITS-1:0] LEAD_RESET = 20'd65000;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_NOTE_ON  = 3'd1,
    OP_NOTE_OFF = 3'd2,
    OP_PLAY     = 3'd3,
    OP_REC      = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    MODE_STANDBY   = 3'd0,
    MODE_PLAY      = 3'd1,
    MODE_REC       = 3'd2,
    MODE_WAIT_PLAY = 3'd3,
    MODE_WAIT_REC  = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CHANNEL_MASK = 2'd0,
    CFG_WAIT_ENABLE  = 2'd1,
    CFG_PLAY_LEAD    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] stamp;
    logic                 is_off;
    logic [6:0]           note;
    logic [6:0]           velocity;
  } entry_t;

endpackage

[sv/merp_ifs.sv]
interface merp_in_if;
  import merp_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [3:0] midi_channel;
  logic [6:0] note_in;
  logic [6:0] velocity_in;
  modport source (output valid, operation, midi_channel, note_in, velocity_in, input ready);
  modport sink (input valid, operation, midi_channel, note_in, velocity_in, output ready);
endinterface

interface merp_out_if;
  import merp_pkg::*;
  logic       valid;
  logic       ready;
  logic       event_is_off;
  logic [6:0] note_out;
  logic [6:0] velocity_out;
  logic       last_of_run;
  logic [2:0] mode_now;
  logic       table_overflow;
  modport source (output valid, event_is_off, note_out, velocity_out, last_of_run, mode_now,
                  table_overflow, input ready);
  modport sink (input valid, event_is_off, note_out, velocity_out, last_of_run, mode_now,
                table_overflow, output ready);
endinterface

interface merp_cfg_if;
  import merp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/merp_event_store.sv]
module merp_event_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [merp_pkg::ADDR_BITS-1:0] wr_addr,
  input  merp_pkg::entry_t             wr_data,
  input  logic                         rd_en,
  input  logic [merp_pkg::ADDR_BITS-1:0] rd_addr,
  output merp_pkg::entry_t             rd_data
);
  import merp_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/midi_event_record_playback.sv]
// Records note-on/note-off transactions with a microsecond time stamp into a 4096-entry
// event table and plays them back against the same time base. Every input transaction
// other than a tick in play mode is handled in the idle state. A tick in play mode first
// walks the table through the single read port of the event table: for each due event it
// reads the entry, then compares its stamp against now plus the lead, up to a quota of
// EVENTS_PER_TICK (20) due events. It then rewinds and reads the same entries again to
// send them out. The input is not ready again until this second pass is done, and a
// stall on the result side holds that pass. Results of a tick leave only after the walk,
// so mode_now and last_of_run reflect the whole tick.
// The table needs no clearing after reset; playback only reads recorded entries.
module midi_event_record_playback (
  input logic clk,
  input logic rst_n,
  merp_in_if.sink    in_ch,
  merp_out_if.source out_ch,
  merp_cfg_if.sink   cfg_ch
);
  import merp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_COMP  = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  localparam logic [IDX_BITS-1:0] DEPTH_IDX = IDX_BITS'(TABLE_DEPTH);
  localparam logic [CNT_BITS-1:0] QUOTA     = CNT_BITS'(EVENTS_PER_TICK);
  localparam logic [CNT_BITS-1:0] CNT_ONE   = CNT_BITS'(1);

  state_t                 state_r, state_nxt;
  mode_t                  mode_r, mode_nxt;
  logic [TIME_BITS-1:0]   elapsed_r, elapsed_nxt;
  logic [TIME_BITS:0]     limit_r, limit_nxt;
  logic [IDX_BITS-1:0]    event_index_r, event_index_nxt;
  logic [IDX_BITS-1:0]    rec_len_r, rec_len_nxt;
  logic                   overflow_r, overflow_nxt;
  logic [MASK_BITS-1:0]   mask_r, mask_nxt;
  logic                   wait_en_r, wait_en_nxt;
  logic [LEAD_BITS-1:0]   lead_r, lead_nxt;
  logic [CNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_is_off_r, out_is_off_nxt;
  logic [6:0]             out_note_r, out_note_nxt;
  logic [6:0]             out_vel_r, out_vel_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [2:0]             out_mode_r, out_mode_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  logic                   wr_en, rd_en;
  entry_t                 wr_data, rd_data;
  logic                   out_free;
  logic [TIME_BITS-1:0]   elapsed_inc;
  logic [IDX_BITS-1:0]    walk_start;

  merp_event_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (event_index_r[ADDR_BITS-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (event_index_r[ADDR_BITS-1:0]),
    .rd_data (rd_data)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.event_is_off   = out_is_off_r;
  assign out_ch.note_out       = out_note_r;
  assign out_ch.velocity_out   = out_vel_r;
  assign out_ch.last_of_run    = out_last_r;
  assign out_ch.mode_now       = out_mode_r;
  assign out_ch.table_overflow = out_ovf_r;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign elapsed_inc = elapsed_r + 1'b1;
  // first entry that this tick found due
  assign walk_start  = event_index_r - {{(IDX_BITS - CNT_BITS){1'b0}}, cnt_r};

  assign wr_data.stamp    = elapsed_r;
  assign wr_data.is_off   = (in_ch.operation == OP_NOTE_OFF);
  assign wr_data.note     = in_ch.note_in;
  assign wr_data.velocity = in_ch.velocity_in;

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    elapsed_nxt     = elapsed_r;
    limit_nxt       = limit_r;
    event_index_nxt = event_index_r;
    rec_len_nxt     = rec_len_r;
    overflow_nxt    = overflow_r;
    mask_nxt        = mask_r;
    wait_en_nxt     = wait_en_r;
    lead_nxt        = lead_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r;
    out_is_off_nxt  = out_is_off_r;
    out_note_nxt    = out_note_r;
    out_vel_nxt     = out_vel_r;
    out_last_nxt    = out_last_r;
    out_mode_nxt    = out_mode_r;
    out_ovf_nxt     = out_ovf_r;
    wr_en           = 1'b0;
    rd_en           = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_CHANNEL_MASK: mask_nxt    = cfg_ch.data[MASK_BITS-1:0];
        CFG_WAIT_ENABLE:  wait_en_nxt = cfg_ch.data[0];
        CFG_PLAY_LEAD:    lead_nxt    = cfg_ch.data[LEAD_BITS-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.operation)
            OP_TICK: begin
              elapsed_nxt = elapsed_inc;
              if (mode_r == MODE_PLAY) begin
                limit_nxt = {1'b0, elapsed_inc} + {{(TIME_BITS + 1 - LEAD_BITS){1'b0}}, lead_r};
                cnt_nxt   = '0;
                state_nxt = ST_CHECK;
              end
            end
            OP_NOTE_ON, OP_NOTE_OFF: begin
              if (mask_r[in_ch.midi_channel]) begin
                if (mode_r == MODE_REC) begin
                  if (event_index_r < DEPTH_IDX) begin
                    wr_en           = 1'b1;
                    event_index_nxt = event_index_r + 1'b1;
                  end else begin
                    overflow_nxt = 1'b1;
                  end
                end else if (in_ch.operation == OP_NOTE_ON && in_ch.note_in == 7'd0) begin
                  if (mode_r == MODE_WAIT_PLAY) begin
                    event_index_nxt = '0;
                    elapsed_nxt     = '0;
                    mode_nxt        = MODE_PLAY;
                  end else if (mode_r == MODE_WAIT_REC) begin
                    event_index_nxt = '0;
                    elapsed_nxt     = '0;
                    mode_nxt        = MODE_REC;
                  end
                end
              end
            end
            OP_PLAY: begin
              if (mode_r == MODE_STANDBY) begin
                if (wait_en_r) begin
                  mode_nxt = MODE_WAIT_PLAY;
                end else begin
                  event_index_nxt = '0;
                  elapsed_nxt     = '0;
                  mode_nxt        = MODE_PLAY;
                end
              end else begin
                if (mode_r == MODE_REC) begin
                  rec_len_nxt = event_index_r;
                end
                mode_nxt = MODE_STANDBY;
              end
            end
            OP_REC: begin
              if (wait_en_r) begin
                mode_nxt = MODE_WAIT_REC;
              end else begin
                event_index_nxt = '0;
                elapsed_nxt     = '0;
                mode_nxt        = MODE_REC;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (event_index_r >= rec_len_r || event_index_r >= DEPTH_IDX) begin
          // end of the recording
          mode_nxt        = MODE_STANDBY;
          event_index_nxt = walk_start;
          state_nxt       = ST_FETCH;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        if ({1'b0, rd_data.stamp} > limit_r) begin
          event_index_nxt = walk_start;
          state_nxt       = ST_FETCH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r + 1'b1 == QUOTA) begin
            event_index_nxt = walk_start;
            state_nxt       = ST_FETCH;
          end else begin
            event_index_nxt = event_index_r + 1'b1;
            state_nxt       = ST_CHECK;
          end
        end
      end
      // second pass: read each due entry again and send it out
      ST_FETCH: begin
        if (cnt_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          rd_en     = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_is_off_nxt  = rd_data.is_off;
          out_note_nxt    = rd_data.note;
          out_vel_nxt     = rd_data.velocity;
          out_last_nxt    = (cnt_r == CNT_ONE);
          out_mode_nxt    = mode_r;
          out_ovf_nxt     = overflow_r;
          event_index_nxt = event_index_r + 1'b1;
          cnt_nxt         = cnt_r - 1'b1;
          state_nxt       = ST_FETCH;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      mode_r        <= MODE_STANDBY;
      elapsed_r     <= '0;
      event_index_r <= '0;
      rec_len_r     <= '0;
      overflow_r    <= 1'b0;
      mask_r        <= MASK_RESET;
      wait_en_r     <= 1'b0;
      lead_r        <= LEAD_RESET;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      mode_r        <= mode_nxt;
      elapsed_r     <= elapsed_nxt;
      event_index_r <= event_index_nxt;
      rec_len_r     <= rec_len_nxt;
      overflow_r    <= overflow_nxt;
      mask_r        <= mask_nxt;
      wait_en_r     <= wait_en_nxt;
      lead_r        <= lead_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    limit_r      <= limit_nxt;
    out_is_off_r <= out_is_off_nxt;
    out_note_r   <= out_note_nxt;
    out_vel_r    <= out_vel_nxt;
    out_last_r   <= out_last_nxt;
    out_mode_r   <= out_mode_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

endmodule
